// ----- hdl/led_button_matrix_scanner_assert.svh -----
// Assertion macros shared by the scanner RTL.
// Each macro expects clk and rst_n to be in scope.
`ifndef LED_BUTTON_MATRIX_SCANNER_ASSERT_SVH
`define LED_BUTTON_MATRIX_SCANNER_ASSERT_SVH

// Same-cycle implication
`define LBMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LBMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/lbms_pkg.sv -----
`default_nettype none

package lbms_pkg;

  // Default geometry
  localparam int MODULES_DEF = 2;
  localparam int COLOURS_DEF = 2;

  // Command codes
  localparam logic [3:0] CMD_ADVANCE     = 4'd0;
  localparam logic [3:0] CMD_SAMPLE      = 4'd1;
  localparam logic [3:0] CMD_LED_BIT_WR  = 4'd2;
  localparam logic [3:0] CMD_LED_BIT_RD  = 4'd3;
  localparam logic [3:0] CMD_LED_BYTE_WR = 4'd4;
  localparam logic [3:0] CMD_LED_BYTE_RD = 4'd5;
  localparam logic [3:0] CMD_BTN_BIT_RD  = 4'd6;
  localparam logic [3:0] CMD_BTN_BYTE_RD = 4'd7;
  localparam logic [3:0] CMD_POLL        = 4'd8;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_IDX  = 2'd1;
  localparam logic [1:0] ST_BAD_COL  = 2'd2;
  localparam logic [1:0] ST_NO_EVENT = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_INV_MASK  = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE  = 2'd1;
  localparam logic [1:0] CFG_DIN_EN    = 2'd2;
  localparam logic [1:0] CFG_CATH_EN   = 2'd3;

  // Configuration reset values
  localparam logic [7:0] INV_MASK_RST = 8'hff;
  localparam logic [7:0] DEBOUNCE_RST = 8'd10;
  localparam logic [1:0] DIN_EN_RST   = 2'b11;
  localparam logic [1:0] CATH_EN_RST  = 2'b11;

  // Request to the button block
  typedef struct packed {
    logic       sample;
    logic       poll;
    logic [2:0] row;
  } btn_ctl_t;

  // Change event found by the button block
  typedef struct packed {
    logic       found;
    logic [6:0] pin;
    logic       value;
  } btn_evt_t;

endpackage

`default_nettype wire

// ----- hdl/lbms_ram.sv -----
`default_nettype none

module lbms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/lbms_led_store.sv -----
`default_nettype none

module lbms_led_store #(
  parameter int MODULES = lbms_pkg::MODULES_DEF,
  parameter int COLOURS = lbms_pkg::COLOURS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [$clog2(MODULES*8)-1:0]         rd_addr,
  input  wire logic                                 wr_en,
  input  wire logic [$clog2(MODULES*8)-1:0]         wr_addr,
  input  wire logic [COLOURS*8-1:0]                 wr_data,
  output logic      [COLOURS*8-1:0]                 rd_data
);

  localparam int ROWS_TOTAL = MODULES * 8;
  localparam int WORD_W     = COLOURS * 8;

  logic [ROWS_TOTAL-1:0] valid_r;
  logic                  hit_valid_r;
  logic                  fwd_r;
  logic [WORD_W-1:0]     fwd_data_r;
  logic [WORD_W-1:0]     ram_q;

  // one word per matrix row, all colour planes side by side
  lbms_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS_TOTAL)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // row valid bits stand in for clearing the RAM at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // bypass for a write landing on the row being read in the same cycle
  always_ff @(posedge clk) begin
    hit_valid_r <= valid_r[rd_addr];
    fwd_r       <= wr_en && (wr_addr == rd_addr);
    fwd_data_r  <= wr_data;
  end

  always_comb begin
    if (fwd_r) begin
      rd_data = fwd_data_r;
    end else if (hit_valid_r) begin
      rd_data = ram_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lbms_buttons.sv -----
`default_nettype none

module lbms_buttons #(
  parameter int MODULES = lbms_pkg::MODULES_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire lbms_pkg::btn_ctl_t                       ctl,
  input  wire logic [((MODULES > 1) ? $clog2(MODULES) : 1)-1:0] mod,
  input  wire logic [15:0]                              buttons,
  input  wire logic [1:0]                               din_enable,
  input  wire logic [7:0]                               deb_reload,
  output logic      [7:0]                               rd_byte,
  output lbms_pkg::btn_evt_t                            evt
);

  localparam int BUS_W = MODULES * 8;
  localparam int MOD_W = (MODULES > 1) ? $clog2(MODULES) : 1;

  // row-major storage: one word per row, module m in byte m
  logic [BUS_W-1:0] levels_r   [8];
  logic [BUS_W-1:0] levels_nxt [8];
  logic [BUS_W-1:0] flags_r    [8];
  logic [BUS_W-1:0] flags_nxt  [8];
  logic [7:0]       debounce_r;
  logic [7:0]       debounce_nxt;

  logic [63:0]      lvl_sel;
  logic [BUS_W-1:0] btn_ext;
  logic [7:0]       en_ext;
  logic [7:0]       cnt;
  logic [7:0]       chg;
  logic             found;
  logic [MOD_W-1:0] fm;
  logic [2:0]       fr;
  logic [2:0]       fb;
  logic [63:0]      flags_f;
  logic [63:0]      lvl_f;
  logic [7:0]       fbyte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 8; r++) begin
        levels_r[r] <= '1;
        flags_r[r]  <= '0;
      end
      debounce_r <= '0;
    end else begin
      for (int r = 0; r < 8; r++) begin
        levels_r[r] <= levels_nxt[r];
        flags_r[r]  <= flags_nxt[r];
      end
      debounce_r <= debounce_nxt;
    end
  end

  // level byte for the bit and byte read commands
  always_comb begin
    lvl_sel = 64'(levels_r[ctl.row]);
    rd_byte = lvl_sel[32'(mod)*8 +: 8];
  end

  // first pending change in module, row, bit order
  always_comb begin
    found = 1'b0;
    fm    = '0;
    fr    = '0;
    fb    = '0;
    for (int m = MODULES - 1; m >= 0; m--) begin
      for (int r = 7; r >= 0; r--) begin
        if (|flags_r[r][m*8 +: 8]) begin
          found = 1'b1;
          fm    = MOD_W'(m);
          fr    = 3'(r);
        end
      end
    end
    flags_f = 64'(flags_r[fr]);
    lvl_f   = 64'(levels_r[fr]);
    fbyte   = flags_f[32'(fm)*8 +: 8];
    for (int b = 7; b >= 0; b--) begin
      if (fbyte[b]) begin
        fb = 3'(b);
      end
    end
    evt.found = found;
    evt.pin   = 7'({fm, fr, fb});
    evt.value = lvl_f[32'(fm)*8 + 32'(fb)];
  end

  // sample with shared debounce counter, and poll clear
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      levels_nxt[r] = levels_r[r];
      flags_nxt[r]  = flags_r[r];
    end
    debounce_nxt = debounce_r;
    btn_ext      = BUS_W'(buttons);
    en_ext       = 8'(din_enable);
    cnt          = (debounce_r != 8'd0) ? debounce_r - 8'd1 : 8'd0;
    chg          = '0;
    if (ctl.sample) begin
      for (int m = 0; m < MODULES; m++) begin
        if (en_ext[m] && (cnt == 8'd0)) begin
          chg = btn_ext[m*8 +: 8] ^ levels_r[ctl.row][m*8 +: 8];
          if (chg != 8'd0) begin
            flags_nxt[ctl.row][m*8 +: 8]  = flags_r[ctl.row][m*8 +: 8] | chg;
            levels_nxt[ctl.row][m*8 +: 8] = btn_ext[m*8 +: 8];
            cnt = deb_reload;
          end
        end
      end
      debounce_nxt = cnt;
    end
    if (ctl.poll && found) begin
      flags_nxt[fr][32'(fm)*8 + 32'(fb)] = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/led_button_matrix_scanner.sv -----
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+--------------------------------
// command  | start, busy, in_*                       | beat taken when start & !busy
// result   | out_strobe, out_*                       | one cycle per beat, no stall
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | beat taken when valid & ready
//
// A command is taken every cycle while busy is low; an advance holds the issue stage for
// one LED-store RAM read per module, and busy is high for all but the last.
// Results pass the issue, execute and result registers to the ports, advance beats
// back to back. Synchronous active-low reset; LED rows read as zero until written.
// Config registers are writable at any time and cfg_ready is always high.
`default_nettype none

`include "led_button_matrix_scanner_assert.svh"

module led_button_matrix_scanner #(
  parameter int MODULES = lbms_pkg::MODULES_DEF,
  parameter int COLOURS = lbms_pkg::COLOURS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  in_cmd,
  input  wire logic [1:0]  in_colour,
  input  wire logic [7:0]  in_pin_index,
  input  wire logic [4:0]  in_byte_index,
  input  wire logic        in_value_bit,
  input  wire logic [7:0]  in_value_byte,
  input  wire logic [15:0] in_button_bits,
  // result channel
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic             out_module_index,
  output logic [7:0]       out_cathode_byte,
  output logic             out_cathode_driven,
  output logic [15:0]      out_colour_bytes,
  output logic [7:0]       out_read_value,
  output logic [6:0]       out_event_pin,
  output logic             out_event_value,
  output logic             out_last,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int ROWS_TOTAL = MODULES * 8;
  localparam int ADDR_W     = $clog2(ROWS_TOTAL);
  localparam int MOD_W      = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int WORD_W     = COLOURS * 8;

  // configuration registers
  logic [7:0] inv_mask_r;
  logic [7:0] debounce_dly_r;
  logic [1:0] din_en_r;
  logic [1:0] cath_en_r;

  logic [2:0] sel_row_r;

  // issue stage
  logic             s1_valid_r;
  logic [3:0]       s1_cmd_r;
  logic [1:0]       s1_colour_r;
  logic [7:0]       s1_pin_r;
  logic [4:0]       s1_bidx_r;
  logic             s1_vbit_r;
  logic [7:0]       s1_vbyte_r;
  logic [15:0]      s1_buttons_r;
  logic [MOD_W-1:0] s1_mod_r;
  logic             s1_adv;
  logic             s1_last;
  logic             accept;
  logic [2:0]       s1_row;
  logic [MOD_W-1:0] s1_mod;
  logic             s1_idx_ok;
  logic             s1_col_ok;
  logic [ADDR_W-1:0] s1_addr;

  // execute stage
  logic              s2_valid_r;
  logic [3:0]        s2_cmd_r;
  logic [1:0]        s2_colour_r;
  logic [2:0]        s2_bit_r;
  logic              s2_vbit_r;
  logic [7:0]        s2_vbyte_r;
  logic [15:0]       s2_buttons_r;
  logic [2:0]        s2_row_r;
  logic [MOD_W-1:0]  s2_mod_r;
  logic              s2_last_r;
  logic              s2_idx_ok_r;
  logic              s2_col_ok_r;
  logic [ADDR_W-1:0] s2_addr_r;

  // LED store and button block
  logic [WORD_W-1:0]  led_word;
  logic [WORD_W-1:0]  led_wdata;
  logic               led_we;
  logic [31:0]        word_ext;
  logic [7:0]         led_byte;
  logic [7:0]         bit_byte;
  logic [7:0]         wr_byte;
  logic [7:0]         cath_en_ext;
  logic [7:0]         btn_byte;
  lbms_pkg::btn_ctl_t btn_ctl;
  lbms_pkg::btn_evt_t btn_evt;

  // result register
  logic        res_strobe;
  logic [1:0]  res_status;
  logic        res_mod;
  logic [7:0]  res_cath;
  logic        res_driven;
  logic [15:0] res_colours;
  logic [7:0]  res_read;
  logic [6:0]  res_epin;
  logic        res_eval;
  logic        res_last;
  logic        out_strobe_r;
  logic [1:0]  out_status_r;
  logic        out_mod_r;
  logic [7:0]  out_cath_r;
  logic        out_driven_r;
  logic [15:0] out_colours_r;
  logic [7:0]  out_read_r;
  logic [6:0]  out_epin_r;
  logic        out_eval_r;
  logic        out_last_r;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_mask_r     <= lbms_pkg::INV_MASK_RST;
      debounce_dly_r <= lbms_pkg::DEBOUNCE_RST;
      din_en_r       <= lbms_pkg::DIN_EN_RST;
      cath_en_r      <= lbms_pkg::CATH_EN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbms_pkg::CFG_INV_MASK: inv_mask_r     <= cfg_data;
        lbms_pkg::CFG_DEBOUNCE: debounce_dly_r <= cfg_data;
        lbms_pkg::CFG_DIN_EN:   din_en_r       <= cfg_data[1:0];
        lbms_pkg::CFG_CATH_EN:  cath_en_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // issue stage control: an advance stays here until it has stepped through every module
  assign s1_adv  = s1_valid_r && (s1_cmd_r == lbms_pkg::CMD_ADVANCE);
  assign s1_last = !s1_adv || (s1_mod_r == MOD_W'(MODULES - 1));
  assign busy    = s1_valid_r && !s1_last;
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept || (s1_valid_r && !s1_last);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r     <= in_cmd;
      s1_colour_r  <= in_colour;
      s1_pin_r     <= in_pin_index;
      s1_bidx_r    <= in_byte_index;
      s1_vbit_r    <= in_value_bit;
      s1_vbyte_r   <= in_value_byte;
      s1_buttons_r <= in_button_bits;
      s1_mod_r     <= '0;
    end else begin
      s1_mod_r <= s1_mod_r + MOD_W'(1);
    end
  end

  // the row moves on when an advance first enters the issue stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_row_r <= '0;
    end else if (s1_adv && (s1_mod_r == '0)) begin
      sel_row_r <= sel_row_r + 3'd1;
    end
  end

  // row, module and RAM address for the command in the issue stage
  always_comb begin
    s1_row    = s1_pin_r[5:3];
    s1_mod    = MOD_W'(s1_pin_r >> 6);
    s1_idx_ok = 10'(s1_pin_r) < 10'(MODULES * 64);
    case (s1_cmd_r)
      lbms_pkg::CMD_ADVANCE: begin
        s1_row    = (s1_mod_r == '0) ? sel_row_r + 3'd1 : sel_row_r;
        s1_mod    = s1_mod_r;
        s1_idx_ok = 1'b1;
      end
      lbms_pkg::CMD_SAMPLE: begin
        s1_row    = sel_row_r - 3'd1;
        s1_idx_ok = 1'b1;
      end
      lbms_pkg::CMD_LED_BYTE_WR, lbms_pkg::CMD_LED_BYTE_RD,
      lbms_pkg::CMD_BTN_BYTE_RD: begin
        s1_row    = s1_bidx_r[2:0];
        s1_mod    = MOD_W'(s1_bidx_r >> 3);
        s1_idx_ok = 7'(s1_bidx_r) < 7'(MODULES * 8);
      end
      default: ;
    endcase
    s1_col_ok = 3'(s1_colour_r) < 3'(COLOURS);
    s1_addr   = ADDR_W'({s1_mod, s1_row});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_cmd_r     <= s1_cmd_r;
    s2_colour_r  <= s1_colour_r;
    s2_bit_r     <= s1_pin_r[2:0];
    s2_vbit_r    <= s1_vbit_r;
    s2_vbyte_r   <= s1_vbyte_r;
    s2_buttons_r <= s1_buttons_r;
    s2_row_r     <= s1_row;
    s2_mod_r     <= s1_mod;
    s2_last_r    <= s1_last;
    s2_idx_ok_r  <= s1_idx_ok;
    s2_col_ok_r  <= s1_col_ok;
    s2_addr_r    <= s1_addr;
  end

  lbms_led_store #(
    .MODULES (MODULES),
    .COLOURS (COLOURS)
  ) u_led_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (s1_addr),
    .wr_en   (led_we),
    .wr_addr (s2_addr_r),
    .wr_data (led_wdata),
    .rd_data (led_word)
  );

  assign btn_ctl.sample = s2_valid_r && (s2_cmd_r == lbms_pkg::CMD_SAMPLE);
  assign btn_ctl.poll   = s2_valid_r && (s2_cmd_r == lbms_pkg::CMD_POLL);
  assign btn_ctl.row    = s2_row_r;

  lbms_buttons #(
    .MODULES (MODULES)
  ) u_buttons (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (btn_ctl),
    .mod        (s2_mod_r),
    .buttons    (s2_buttons_r),
    .din_enable (din_en_r),
    .deb_reload (debounce_dly_r),
    .rd_byte    (btn_byte),
    .evt        (btn_evt)
  );

  // colour byte of the row word, and its updated form for writes
  always_comb begin
    word_ext = 32'(led_word);
    led_byte = word_ext[32'(s2_colour_r)*8 +: 8];
    bit_byte = led_byte;
    bit_byte[s2_bit_r] = s2_vbit_r;
    wr_byte  = (s2_cmd_r == lbms_pkg::CMD_LED_BIT_WR) ? bit_byte : s2_vbyte_r;
    led_wdata = led_word;
    for (int c = 0; c < COLOURS; c++) begin
      if (2'(c) == s2_colour_r) begin
        led_wdata[c*8 +: 8] = wr_byte;
      end
    end
  end

  assign cath_en_ext = 8'(cath_en_r);

  // execute: build the result beat
  always_comb begin
    res_strobe  = s2_valid_r;
    res_status  = lbms_pkg::ST_OK;
    res_mod     = 1'b0;
    res_cath    = '0;
    res_driven  = 1'b0;
    res_colours = '0;
    res_read    = '0;
    res_epin    = '0;
    res_eval    = 1'b0;
    res_last    = 1'b1;
    led_we      = 1'b0;
    case (s2_cmd_r)
      lbms_pkg::CMD_ADVANCE: begin
        res_mod     = s2_mod_r[0];
        res_cath    = ~(8'd1 << s2_row_r) ^ inv_mask_r;
        res_driven  = cath_en_ext[s2_mod_r];
        res_colours = 16'(led_word);
        res_last    = s2_last_r;
      end
      lbms_pkg::CMD_SAMPLE: ;
      lbms_pkg::CMD_LED_BIT_WR, lbms_pkg::CMD_LED_BIT_RD,
      lbms_pkg::CMD_LED_BYTE_WR, lbms_pkg::CMD_LED_BYTE_RD: begin
        if (!s2_idx_ok_r) begin
          res_status = lbms_pkg::ST_BAD_IDX;
        end else if (!s2_col_ok_r) begin
          res_status = lbms_pkg::ST_BAD_COL;
        end else if (s2_cmd_r inside {lbms_pkg::CMD_LED_BIT_WR,
                                      lbms_pkg::CMD_LED_BYTE_WR}) begin
          led_we = s2_valid_r;
        end else if (s2_cmd_r == lbms_pkg::CMD_LED_BIT_RD) begin
          res_read = 8'(led_byte[s2_bit_r]);
        end else begin
          res_read = led_byte;
        end
      end
      lbms_pkg::CMD_BTN_BIT_RD, lbms_pkg::CMD_BTN_BYTE_RD: begin
        if (!s2_idx_ok_r) begin
          res_status = lbms_pkg::ST_BAD_IDX;
        end else if (s2_cmd_r == lbms_pkg::CMD_BTN_BIT_RD) begin
          res_read = 8'(btn_byte[s2_bit_r]);
        end else begin
          res_read = btn_byte;
        end
      end
      lbms_pkg::CMD_POLL: begin
        if (btn_evt.found) begin
          res_epin = btn_evt.pin;
          res_eval = btn_evt.value;
        end else begin
          res_status = lbms_pkg::ST_NO_EVENT;
        end
      end
      default: res_strobe = 1'b0;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res_strobe;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= res_status;
    out_mod_r     <= res_mod;
    out_cath_r    <= res_cath;
    out_driven_r  <= res_driven;
    out_colours_r <= res_colours;
    out_read_r    <= res_read;
    out_epin_r    <= res_epin;
    out_eval_r    <= res_eval;
    out_last_r    <= res_last;
  end

  assign out_strobe         = out_strobe_r;
  assign out_status         = out_status_r;
  assign out_module_index   = out_mod_r;
  assign out_cathode_byte   = out_cath_r;
  assign out_cathode_driven = out_driven_r;
  assign out_colour_bytes   = out_colours_r;
  assign out_read_value     = out_read_r;
  assign out_event_pin      = out_epin_r;
  assign out_event_value    = out_eval_r;
  assign out_last           = out_last_r;

  // checks
  `LBMS_ASSERT_IMP(a_busy_only_adv, busy, s1_adv, "busy outside a multi-beat advance")
  `LBMS_ASSERT_NXT(a_adv_beats_contig, out_strobe_r && !out_last_r, out_strobe_r,
                   "advance beats not back to back")
  `LBMS_ASSERT_IMP(a_led_we_valid, led_we, s2_valid_r && s2_idx_ok_r && s2_col_ok_r,
                   "LED store written without a valid in-range command")

endmodule

`default_nettype wire
